// File: hw/rtl/lsle_pkg.sv
// ----------------------------------------------------------------------------
// lsle_pkg: layer stack list engine package
// Field widths, opcodes and defaults shared by the interfaces and the engine.
// ----------------------------------------------------------------------------
package lsle_pkg;

  localparam int OPCODE_W         = 3;
  localparam int LAYER_W          = 8;
  localparam int STACK_SLOTS_DEF  = 8;

  // operation codes carried in the opcode field
  localparam logic [OPCODE_W-1:0] OP_PUSH        = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_POP         = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_REMOVE      = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_REMOVE_PUSH = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_TOGGLE      = 3'd4;

endpackage

// File: hw/rtl/lsle_intf.sv
// ----------------------------------------------------------------------------
// lsle_intf: layer stack list engine channels
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface lsle_in_if;
  import lsle_pkg::*;

  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [LAYER_W-1:0]  layer;

  modport source (output valid, output opcode, output layer, input ready);
  modport sink   (input valid, input opcode, input layer, output ready);
endinterface

interface lsle_out_if;
  import lsle_pkg::*;

  logic               valid;
  logic               ready;
  logic               ok;
  logic [LAYER_W-1:0] head_layer;
  logic               stack_empty;

  modport source (output valid, output ok, output head_layer, output stack_empty,
                  input ready);
  modport sink   (input valid, input ok, input head_layer, input stack_empty,
                  output ready);
endinterface

// File: hw/rtl/layer_stack_list_engine.sv
// ----------------------------------------------------------------------------
// layer_stack_list_engine: linked-list layer stack in a slot array
// Push, pop, remove, remove-then-push and toggle on a stack of layer numbers
// kept as a singly linked list in a slot memory, one result item per request.
// ----------------------------------------------------------------------------
//
//   channel   dir   handshake              payload
//   in_chan   in    in_chan.valid/ready    opcode[2:0], layer[7:0]
//   out_chan  out   out_chan.valid/ready   ok, head_layer[7:0], stack_empty
//
// one request at a time: in_chan.ready is high only while the sequencer idles
// each request steps through the sequencer states; the remove walk reads one
// chain slot at a time, the push free search scans one slot per cycle, all
// set by the single read port of the slot memory and the one comparator
// synchronous active-low reset clears all in-use bits and the top index;
// slot memory needs no clearing: a slot's contents matter only while in use
// a stalled out_chan holds the result register; the sequencer waits on it
//
module layer_stack_list_engine #(
  parameter int STACK_SLOTS = lsle_pkg::STACK_SLOTS_DEF
) (
  input logic          clk,
  input logic          rst_n,
  lsle_in_if.sink      in_chan,
  lsle_out_if.source   out_chan
);
  import lsle_pkg::*;

  localparam int IW = (STACK_SLOTS > 1) ? $clog2(STACK_SLOTS) : 1;
  localparam logic [IW-1:0] LAST_SLOT = IW'(STACK_SLOTS - 1);
  localparam logic [IW-1:0] FIRST_SLOT = IW'(1);

  // one slot memory entry: layer held and link toward the bottom
  typedef struct packed {
    logic [LAYER_W-1:0] layer;
    logic [IW-1:0]      link;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_POP,
    S_RM_TOP,
    S_WALK,
    S_RM_END,
    S_FREE,
    S_TOP,
    S_TOP_WAIT
  } state_t;

  // slot memory, one write and one registered read per cycle
  entry_t slot_mem [STACK_SLOTS];
  entry_t rd_q;
  logic   rd_en;
  logic [IW-1:0] rd_addr;
  logic   wr_en;
  logic [IW-1:0] wr_addr;
  entry_t wr_data;

  state_t state_r, state_nxt;
  logic [STACK_SLOTS-1:0] used_r, used_nxt;   // in-use bit per slot
  logic [IW-1:0] top_r, top_nxt;              // top slot, 0 is the sentinel
  logic [IW-1:0] idx_r, idx_nxt;              // free search pointer
  logic [IW-1:0] cur_r, cur_nxt;              // walk: slot before the candidate
  logic [IW-1:0] nxt_r, nxt_nxt;              // walk: candidate slot
  logic [LAYER_W-1:0] cur_layer_r, cur_layer_nxt;
  logic [OPCODE_W-1:0] op_r, op_nxt;
  logic [LAYER_W-1:0] layer_r, layer_nxt;
  logic ok_r, ok_nxt;
  logic removed_r, removed_nxt;

  // result register
  logic out_valid_r, out_valid_nxt;
  logic out_ok_r, out_ok_nxt;
  logic [LAYER_W-1:0] out_top_r, out_top_nxt;
  logic out_empty_r, out_empty_nxt;

  logic out_free;

  assign out_free = !out_valid_r || out_chan.ready;

  assign in_chan.ready        = (state_r == S_IDLE);
  assign out_chan.valid       = out_valid_r;
  assign out_chan.ok          = out_ok_r;
  assign out_chan.head_layer  = out_top_r;
  assign out_chan.stack_empty = out_empty_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= slot_mem[rd_addr];
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    used_nxt      = used_r;
    top_nxt       = top_r;
    idx_nxt       = idx_r;
    cur_nxt       = cur_r;
    nxt_nxt       = nxt_r;
    cur_layer_nxt = cur_layer_r;
    op_nxt        = op_r;
    layer_nxt     = layer_r;
    ok_nxt        = ok_r;
    removed_nxt   = removed_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_ok_nxt    = out_ok_r;
    out_top_nxt   = out_top_r;
    out_empty_nxt = out_empty_r;
    rd_en         = 1'b0;
    rd_addr       = top_r;
    wr_en         = 1'b0;
    wr_addr       = top_r;
    wr_data       = '0;

    case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          op_nxt    = in_chan.opcode;
          layer_nxt = in_chan.layer;
          state_nxt = S_START;
        end
      end

      S_START: begin
        ok_nxt      = 1'b0;
        removed_nxt = 1'b0;
        idx_nxt     = FIRST_SLOT;
        case (op_r)
          OP_PUSH: state_nxt = S_FREE;
          OP_POP: begin
            if (used_r[top_r]) begin
              rd_en     = 1'b1;
              state_nxt = S_POP;
            end else begin
              state_nxt = S_TOP;
            end
          end
          OP_REMOVE, OP_REMOVE_PUSH, OP_TOGGLE: begin
            if (used_r[top_r]) begin
              rd_en     = 1'b1;
              state_nxt = S_RM_TOP;
            end else begin
              state_nxt = S_RM_END;
            end
          end
          default: state_nxt = S_TOP;
        endcase
      end

      // top entry in rd_q: unlink it
      S_POP: begin
        used_nxt[top_r] = 1'b0;
        top_nxt         = rd_q.link;
        ok_nxt          = 1'b1;
        state_nxt       = S_TOP;
      end

      // top entry in rd_q: match pops it, else start the chain walk
      S_RM_TOP: begin
        if (rd_q.layer == layer_r) begin
          used_nxt[top_r] = 1'b0;
          top_nxt         = rd_q.link;
          removed_nxt     = 1'b1;
          state_nxt       = S_RM_END;
        end else begin
          cur_nxt       = top_r;
          cur_layer_nxt = rd_q.layer;
          nxt_nxt       = rd_q.link;
          if (used_r[rd_q.link]) begin
            rd_en     = 1'b1;
            rd_addr   = rd_q.link;
            state_nxt = S_WALK;
          end else begin
            state_nxt = S_RM_END;
          end
        end
      end

      // candidate entry in rd_q: match relinks its predecessor around it
      S_WALK: begin
        if (rd_q.layer == layer_r) begin
          wr_en           = 1'b1;
          wr_addr         = cur_r;
          wr_data.layer   = cur_layer_r;
          wr_data.link    = rd_q.link;
          used_nxt[nxt_r] = 1'b0;
          removed_nxt     = 1'b1;
          state_nxt       = S_RM_END;
        end else begin
          cur_nxt       = nxt_r;
          cur_layer_nxt = rd_q.layer;
          nxt_nxt       = rd_q.link;
          if (used_r[rd_q.link]) begin
            rd_en     = 1'b1;
            rd_addr   = rd_q.link;
            state_nxt = S_WALK;
          end else begin
            state_nxt = S_RM_END;
          end
        end
      end

      S_RM_END: begin
        case (op_r)
          OP_REMOVE: begin
            ok_nxt    = removed_r;
            state_nxt = S_TOP;
          end
          OP_TOGGLE: begin
            if (removed_r) begin
              ok_nxt    = 1'b1;
              state_nxt = S_TOP;
            end else begin
              state_nxt = S_FREE;
            end
          end
          default: state_nxt = S_FREE;
        endcase
      end

      // lowest free slot search, one slot per cycle
      S_FREE: begin
        if (!used_r[idx_r]) begin
          wr_en           = 1'b1;
          wr_addr         = idx_r;
          wr_data.layer   = layer_r;
          wr_data.link    = top_r;
          used_nxt[idx_r] = 1'b1;
          top_nxt         = idx_r;
          ok_nxt          = 1'b1;
          state_nxt       = S_TOP;
        end else if (idx_r == LAST_SLOT) begin
          ok_nxt    = 1'b0;
          state_nxt = S_TOP;
        end else begin
          idx_nxt = idx_r + FIRST_SLOT;
        end
      end

      S_TOP: begin
        rd_en     = 1'b1;
        state_nxt = S_TOP_WAIT;
      end

      // rd_q holds the top entry; wait for the result register to free up
      S_TOP_WAIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = ok_r;
          out_top_nxt   = used_r[top_r] ? rd_q.layer : '0;
          out_empty_nxt = !used_r[top_r];
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      top_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      top_r       <= top_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r       <= idx_nxt;
    cur_r       <= cur_nxt;
    nxt_r       <= nxt_nxt;
    cur_layer_r <= cur_layer_nxt;
    op_r        <= op_nxt;
    layer_r     <= layer_nxt;
    ok_r        <= ok_nxt;
    removed_r   <= removed_nxt;
    out_ok_r    <= out_ok_nxt;
    out_top_r   <= out_top_nxt;
    out_empty_r <= out_empty_nxt;
  end

endmodule

// File: tb/lsle_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lsle_checker: layer stack scoreboard
// Watches the request and result channels, keeps its own copy of the layer
// stack and compares every result item field by field in arrival order.
// ----------------------------------------------------------------------------
module lsle_checker #(
  parameter int STACK_SLOTS = lsle_pkg::STACK_SLOTS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  lsle_in_if   req_mon,
  lsle_out_if  rsp_mon,
  output int   mismatches,
  output int   outstanding
);
  import lsle_pkg::*;

  localparam int IDX_W = (STACK_SLOTS > 2) ? $clog2(STACK_SLOTS) : 1;

  typedef struct packed {
    logic               ok;
    logic [LAYER_W-1:0] head_layer;
    logic               stack_empty;
  } stack_status_t;

  // shadow copy of the slot array
  logic [LAYER_W-1:0] slot_layer [STACK_SLOTS];
  logic [IDX_W-1:0]   slot_link  [STACK_SLOTS];
  logic               slot_used  [STACK_SLOTS];
  logic [IDX_W-1:0]   top_idx;

  stack_status_t pending_status [$];
  int            results_seen;

  initial mismatches = 0;

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    mismatches = mismatches + 1;
  endtask

  function automatic void free_slot(input logic [IDX_W-1:0] s);
    slot_layer[s] = '0;
    slot_link[s]  = '0;
    slot_used[s]  = 1'b0;
  endfunction

  // lowest free slot from 1 upward becomes the new top
  function automatic bit stack_push(input logic [LAYER_W-1:0] lay);
    for (int i = 1; i < STACK_SLOTS; i++) begin
      if (!slot_used[i]) begin
        slot_layer[i] = lay;
        slot_link[i]  = top_idx;
        slot_used[i]  = 1'b1;
        top_idx       = IDX_W'(i);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic bit stack_pop();
    logic [IDX_W-1:0] t;
    t = top_idx;
    if (!slot_used[t]) return 1'b0;
    top_idx = slot_link[t];
    free_slot(t);
    return 1'b1;
  endfunction

  // unlink the match nearest the top
  function automatic bit stack_remove(input logic [LAYER_W-1:0] lay);
    logic [IDX_W-1:0] cur;
    logic [IDX_W-1:0] nxt;
    cur = top_idx;
    if (slot_used[cur] && slot_layer[cur] == lay) return stack_pop();
    for (int s = 0; s < STACK_SLOTS && slot_used[cur]; s++) begin
      nxt = slot_link[cur];
      if (slot_used[nxt] && slot_layer[nxt] == lay) begin
        slot_link[cur] = slot_link[nxt];
        free_slot(nxt);
        return 1'b1;
      end
      cur = nxt;
    end
    return 1'b0;
  endfunction

  function automatic stack_status_t stack_step(input logic [OPCODE_W-1:0] op,
                                               input logic [LAYER_W-1:0]  lay);
    stack_status_t r;
    logic          done;
    done = 1'b0;
    case (op)
      OP_PUSH:        done = stack_push(lay);
      OP_POP:         done = stack_pop();
      OP_REMOVE:      done = stack_remove(lay);
      OP_REMOVE_PUSH: begin
        void'(stack_remove(lay));
        done = stack_push(lay);
      end
      OP_TOGGLE: begin
        done = stack_remove(lay);
        if (!done) done = stack_push(lay);
      end
      default:        done = 1'b0;
    endcase
    r.ok          = done;
    r.head_layer  = slot_used[top_idx] ? slot_layer[top_idx] : '0;
    r.stack_empty = !slot_used[top_idx];
    return r;
  endfunction

  always @(posedge clk) begin
    stack_status_t want;
    if (!rst_n) begin
      for (int i = 0; i < STACK_SLOTS; i++) free_slot(IDX_W'(i));
      top_idx = '0;
      pending_status.delete();
      results_seen = 0;
    end else begin
      if (req_mon.valid && req_mon.ready)
        pending_status.push_back(stack_step(req_mon.opcode, req_mon.layer));
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (pending_status.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with none expected", results_seen));
        end else begin
          want = pending_status.pop_front();
          if (rsp_mon.ok !== want.ok)
            report_mismatch($sformatf("result %0d ok got %b expected %b",
                                      results_seen, rsp_mon.ok, want.ok));
          if (rsp_mon.head_layer !== want.head_layer)
            report_mismatch($sformatf("result %0d head_layer got %0d expected %0d",
                                      results_seen, rsp_mon.head_layer,
                                      want.head_layer));
          if (rsp_mon.stack_empty !== want.stack_empty)
            report_mismatch($sformatf("result %0d stack_empty got %b expected %b",
                                      results_seen, rsp_mon.stack_empty,
                                      want.stack_empty));
        end
        results_seen++;
      end
    end
    outstanding <= pending_status.size();
  end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: layer stack list engine testbench
// Drives a directed opening and a long random run of stack operations in
// bursts against a stalling receiver; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
  import lsle_pkg::*;

  // opcodes the engine must treat as no-ops
  localparam logic [OPCODE_W-1:0] OP_UNDEF_A = 3'd5;
  localparam logic [OPCODE_W-1:0] OP_UNDEF_B = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_UNDEF_C = 3'd7;

  localparam int RANDOM_ITEMS = 650;
  localparam int PHASE_LEN    = 40;      // items per fill or drain phase
  localparam int HOLD_AT      = 120;     // items sent before the long stall
  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = 60;      // covers the slowest remove-or-push
  localparam int CYCLE_LIMIT  = 200000;

  logic clk;
  logic rst_n;
  int   mismatches;
  int   outstanding;
  int   items_sent;
  int   cycles;

  lsle_in_if  req_if ();
  lsle_out_if rsp_if ();

  layer_stack_list_engine dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (req_if),
    .out_chan (rsp_if)
  );

  lsle_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_mon     (req_if),
    .rsp_mon     (rsp_if),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // hard stop in case the engine hangs
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // offer one item from the current edge and return at the edge it is taken;
  // valid stays high so a following item goes out back to back
  task automatic drive_item(input logic [OPCODE_W-1:0] op, input logic [LAYER_W-1:0] lay);
    req_if.valid  <= 1'b1;
    req_if.opcode <= op;
    req_if.layer  <= lay;
    do @(posedge clk); while (!req_if.ready);
    items_sent++;
  endtask

  task automatic idle_sender(input int n);
    req_if.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // small pool most of the time so removes and duplicates find matches
  function automatic logic [LAYER_W-1:0] pick_layer();
    if ($urandom_range(0, 9) < 7) return LAYER_W'($urandom_range(0, 5));
    return LAYER_W'($urandom_range(0, 255));
  endfunction

  // fill phases lean on push, drain phases on pop and remove
  function automatic logic [OPCODE_W-1:0] pick_opcode(input bit filling);
    int r;
    r = $urandom_range(0, 99);
    if (filling) begin
      if (r < 45) return OP_PUSH;
      if (r < 60) return OP_TOGGLE;
      if (r < 72) return OP_REMOVE_PUSH;
      if (r < 84) return OP_POP;
      if (r < 96) return OP_REMOVE;
    end else begin
      if (r < 15) return OP_PUSH;
      if (r < 30) return OP_TOGGLE;
      if (r < 40) return OP_REMOVE_PUSH;
      if (r < 68) return OP_POP;
      if (r < 96) return OP_REMOVE;
    end
    case ($urandom_range(0, 2))
      0:       return OP_UNDEF_A;
      1:       return OP_UNDEF_B;
      default: return OP_UNDEF_C;
    endcase
  endfunction

  // receiver: ready pattern switches among random modes, plus one long
  // hold-off so the engine backs up and drops in_chan ready
  initial begin
    int  cyc;
    int  mode;
    bit  held_off;
    cyc      = 0;
    mode     = 0;
    held_off = 1'b0;
    rsp_if.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      @(posedge clk);
      if (!held_off && items_sent >= HOLD_AT) begin
        held_off = 1'b1;
        rsp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (cyc % 64 == 0) mode = $urandom_range(0, 3);
        case (mode)
          0:       rsp_if.ready <= 1'b1;                        // never stalls
          1:       rsp_if.ready <= ($urandom_range(0, 3) != 0);
          2:       rsp_if.ready <= ((cyc % 8) < 5);             // fixed on/off
          default: rsp_if.ready <= ($urandom_range(0, 3) == 0); // mostly stalled
        endcase
        cyc++;
      end
    end
  end

  // sender and verdict
  initial begin
    int  burst;
    bit  filling;
    int  n;
    items_sent = 0;
    req_if.valid  <= 1'b0;
    req_if.opcode <= OP_PUSH;
    req_if.layer  <= '0;
    rst_n <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed opening on an empty stack
    drive_item(OP_POP, 8'd0);            // pop on empty fails
    drive_item(OP_REMOVE, 8'd9);         // remove on empty fails
    drive_item(OP_UNDEF_C, 8'd255);      // unknown opcode, empty report
    drive_item(OP_PUSH, 8'd0);
    drive_item(OP_PUSH, 8'd255);
    drive_item(OP_PUSH, 8'd3);
    drive_item(OP_PUSH, 8'd3);           // duplicate layer
    drive_item(OP_PUSH, 8'd128);
    drive_item(OP_PUSH, 8'd1);
    drive_item(OP_PUSH, 8'd2);           // every slot but sentinel slot 0 now in use
    drive_item(OP_PUSH, 8'd77);          // push on full fails
    drive_item(OP_TOGGLE, 8'd77);        // no match and full
    drive_item(OP_REMOVE_PUSH, 8'd77);   // push half fails on full
    drive_item(OP_UNDEF_A, 8'd170);      // unknown opcode on full stack
    drive_item(OP_REMOVE, 8'd3);         // takes the copy nearest the top
    drive_item(OP_REMOVE, 8'd0);         // bottom entry
    drive_item(OP_REMOVE, 8'd2);         // top entry
    drive_item(OP_REMOVE, 8'd99);        // no match on a full walk
    drive_item(OP_REMOVE_PUSH, 8'd255);  // moves an entry to the top
    drive_item(OP_TOGGLE, 8'd255);       // toggle removes
    drive_item(OP_TOGGLE, 8'd85);        // toggle pushes
    drive_item(OP_UNDEF_B, 8'd15);
    drive_item(OP_POP, 8'd240);
    drive_item(OP_POP, 8'd0);
    drive_item(OP_REMOVE_PUSH, 8'd4);    // nothing to remove, push only

    // random part in bursts; some bursts run straight on with no gap
    n = 0;
    while (n < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && n < RANDOM_ITEMS) begin
        filling = ((n / PHASE_LEN) % 2 == 0);
        drive_item(pick_opcode(filling), pick_layer());
        burst--;
        n++;
      end
      if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 6));
    end

    // let the last item reach the checker before watching the queue
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/lsle_pkg.sv
hw/rtl/lsle_intf.sv
hw/rtl/layer_stack_list_engine.sv
tb/lsle_checker.sv
tb/tb_top.sv
